>>> rtl/flv_audio_tag_header_packer_defines.svh
// Assertion macros used by the FLV audio tag header packer checker
`ifndef FLV_AUDIO_TAG_HEADER_PACKER_DEFINES_SVH
`define FLV_AUDIO_TAG_HEADER_PACKER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define FLVAHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FLVAHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/flvahp_pkg.sv
// Types and constants of the FLV audio tag header packer
package flvahp_pkg;

  localparam int FRAME_LEN_W = 13;
  localparam int RATE_W      = 17;
  localparam int TS_W        = 32;
  localparam int SIZE_W      = 14;
  localparam int ADDR_W      = 3;
  localparam int MS_PER_S    = 1000;

  // register index carried by paddr[ADDR_W-1]
  localparam logic REG_CODEC_MODE = 1'b0;

  // codec_mode values
  localparam logic CODEC_MP3 = 1'b0;
  localparam logic CODEC_AAC = 1'b1;

  // FLV tag constants
  localparam logic [7:0]        TAG_TYPE_AUDIO = 8'h08;
  localparam logic [SIZE_W-1:0] TAG_HDR_LEN    = 14'd11;
  localparam logic [7:0]        FLAGS_MP3      = 8'h22;
  localparam logic [7:0]        FLAGS_AAC      = 8'hAF;
  localparam logic [7:0]        AAC_PKT_SEQ    = 8'h00;
  localparam logic [7:0]        AAC_PKT_RAW    = 8'h01;
  localparam logic [7:0]        AAC_OBJ_LC     = 8'h10;

  // MP3 sound rate codes
  localparam logic [RATE_W-1:0] RATE_11K       = 17'd11025;
  localparam logic [RATE_W-1:0] RATE_22K       = 17'd22050;
  localparam logic [1:0]        MP3_RATE_11K   = 2'd1;
  localparam logic [1:0]        MP3_RATE_22K   = 2'd2;
  localparam logic [1:0]        MP3_RATE_OTHER = 2'd3;

  localparam logic [RATE_W-1:0] AAC_RATES [13] = '{
    17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000, 17'd24000,
    17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000, 17'd7350
  };

  typedef struct packed {
    logic [FRAME_LEN_W-1:0] frame_len;
    logic [3:0]             sync_len;
    logic [11:0]            frame_samples;
    logic [RATE_W-1:0]      sample_rate;
    logic [2:0]             channel_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tag_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } aac_rate_t;

  // AAC sampling frequency index lookup
  function automatic aac_rate_t aac_rate_lookup(input logic [RATE_W-1:0] rate);
    aac_rate_t r;
    r = '0;
    for (int i = 12; i >= 0; i--) begin
      if (rate == AAC_RATES[i]) begin
        r.hit = 1'b1;
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/flvahp_div.sv
// Bit-serial divider: low 32 bits of floor(total*1000/rate)
module flvahp_div
  import flvahp_pkg::*;
#(
  parameter int TOTAL_W = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TOTAL_W-1:0] total,
  input  logic [RATE_W-1:0] rate,
  output div_status_t       status,
  output logic [TS_W-1:0]   quo
);

  localparam int NUM_W = TOTAL_W + $clog2(MS_PER_S);
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } div_state_t;

  div_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [RATE_W-1:0] rem_r;
  logic [TS_W-1:0]   quo_r;

  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;

  // one restoring step: bring in the next numerator bit, subtract if it fits
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, rate};
  assign diff  = trial - {1'b0, rate};

  // control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          state_nxt = D_RUN;
          cnt_nxt   = CNT_W'(NUM_W - 1);
        end
      end
      D_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = D_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath: scale to milliseconds on start (x1000 as x1024 - x16 - x8),
  // then one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && start) begin
      num_r <= (NUM_W'(total) << 10) - (NUM_W'(total) << 4) - (NUM_W'(total) << 3);
      rem_r <= '0;
    end else if (state_r == D_RUN) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo_r <= {quo_r[TS_W-2:0], ge};
    end
  end

  assign status.busy = (state_r == D_RUN);
  assign status.done = done_r;
  assign quo         = quo_r;

endmodule

>>> rtl/flv_audio_tag_header_packer.sv
// FLV audio tag header packer: byte-serial tag header emitter with serial timestamp divider
// Output: an accepted item sets the emitter state, then the output register gives one byte
//   per cycle while out_stall is low: 16 bytes per MP3 frame, 17 per AAC frame, with 17 or
//   19 sequence-header bytes in front of the first AAC frame.
// Input: the next item is held off while a header is being emitted and, with a non-zero
//   sample rate, until the one-bit-per-cycle timestamp divider has finished.
// Reset: synchronous, active low, no clearing pass; snapshot and output data stay unreset.
module flv_audio_tag_header_packer
  import flvahp_pkg::*;
#(
  parameter int SAMPLE_TOTAL_BITS = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    E_IDLE  = 3'b001,
    E_SEQ   = 3'b010,
    E_FRAME = 3'b100
  } emit_state_t;

  // state
  logic                         codec_mode_r, codec_mode_nxt;
  logic                         first_done_r, first_done_nxt;
  logic [7:0]                   flags_r, flags_nxt;
  logic [SIZE_W-1:0]            prev_r, prev_nxt;
  logic [TS_W-1:0]              ts_r, ts_nxt;
  logic [SAMPLE_TOTAL_BITS-1:0] total_r, total_nxt;
  logic                         start_r, start_nxt;
  emit_state_t                  emit_r, emit_nxt;
  logic [4:0]                   idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_data_r, out_data_nxt;

  // per-item snapshot
  logic [SIZE_W-1:0]            seq_prev_r;
  logic [SIZE_W-1:0]            fr_prev_r;
  logic [SIZE_W-1:0]            fr_dsize_r;
  logic [7:0]                   fr_flag_r;
  logic                         fr_aac_r;
  logic                         cfg_hit_r;
  logic [7:0]                   cfg_b0_r;
  logic [7:0]                   cfg_b1_r;
  logic [TS_W-1:0]              ts_snap_r;
  logic [RATE_W-1:0]            rate_r;

  logic                         accept;
  logic                         cfg_wr;
  logic                         out_ready;
  logic                         is_mp3;
  logic                         seq_needed;
  logic                         hl_gt;
  logic [FRAME_LEN_W-1:0]       pay_len;
  aac_rate_t                    aac_rate;
  logic [1:0]                   mp3_code;
  logic [7:0]                   flags_now;
  logic [SIZE_W-1:0]            dsize_new;
  logic [SIZE_W-1:0]            seq_dsize;

  logic [23:0]                  tag_prev;
  logic [23:0]                  tag_dsize;
  logic [4:0]                   tag_last_idx;
  logic                         tag_end;
  logic [7:0]                   cur_byte;

  div_status_t                  div_stat;
  logic [TS_W-1:0]              div_quo;

  assign accept    = in_valid && !in_stall;
  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = (emit_r != E_IDLE) || start_r || div_stat.busy || div_stat.done;

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_CODEC_MODE) ? 32'(codec_mode_r) : '0;
  assign codec_mode_nxt = (cfg_wr && paddr[ADDR_W-1] == REG_CODEC_MODE) ? pwdata[0]
                                                                          : codec_mode_r;

  // item decode
  assign is_mp3     = (codec_mode_r == CODEC_MP3);
  assign seq_needed = (codec_mode_r == CODEC_AAC) && !first_done_r;
  assign hl_gt      = {9'b0, in_data.sync_len} > in_data.frame_len;
  assign pay_len    = in_data.frame_len - (hl_gt ? in_data.frame_len
                                                 : {9'b0, in_data.sync_len});
  assign aac_rate   = aac_rate_lookup(in_data.sample_rate);

  always_comb begin
    if (in_data.sample_rate == RATE_11K) begin
      mp3_code = MP3_RATE_11K;
    end else if (in_data.sample_rate == RATE_22K) begin
      mp3_code = MP3_RATE_22K;
    end else begin
      mp3_code = MP3_RATE_OTHER;
    end
  end

  // MP3 flags latch from the first frame while still at the base value
  assign flags_now = (is_mp3 && flags_r == FLAGS_MP3)
                   ? (FLAGS_MP3 | {4'b0, mp3_code, 2'b0} | {7'b0, in_data.channel_count == 3'd2})
                   : flags_r;
  assign dsize_new = is_mp3 ? ({1'b0, in_data.frame_len} + 14'd1)
                            : ({1'b0, pay_len} + 14'd2);
  assign seq_dsize = aac_rate.hit ? 14'd4 : 14'd2;

  // running state
  always_comb begin
    first_done_nxt = first_done_r;
    flags_nxt      = flags_r;
    prev_nxt       = prev_r;
    total_nxt      = total_r;
    start_nxt      = 1'b0;
    ts_nxt         = div_stat.done ? div_quo : ts_r;
    if (accept) begin
      first_done_nxt = 1'b1;
      flags_nxt      = seq_needed ? FLAGS_AAC : flags_now;
      prev_nxt       = dsize_new + TAG_HDR_LEN;
      total_nxt      = total_r + SAMPLE_TOTAL_BITS'(in_data.frame_samples);
      start_nxt      = (in_data.sample_rate != '0);
    end
  end

  // snapshot of what the tags of this item carry
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_prev_r <= prev_r;
      fr_prev_r  <= seq_needed ? (seq_dsize + TAG_HDR_LEN) : prev_r;
      fr_dsize_r <= dsize_new;
      fr_flag_r  <= is_mp3 ? flags_now : FLAGS_AAC;
      fr_aac_r   <= !is_mp3;
      cfg_hit_r  <= aac_rate.hit;
      cfg_b0_r   <= AAC_OBJ_LC | {5'b0, aac_rate.idx[3:1]};
      cfg_b1_r   <= {aac_rate.idx[0], 1'b0, in_data.channel_count, 3'b0};
      ts_snap_r  <= ts_r;
      rate_r     <= in_data.sample_rate;
    end
  end

  // current tag fields
  assign tag_prev     = {10'b0, (emit_r == E_SEQ) ? seq_prev_r : fr_prev_r};
  assign tag_dsize    = {10'b0, (emit_r == E_SEQ) ? (cfg_hit_r ? 14'd4 : 14'd2) : fr_dsize_r};
  assign tag_last_idx = (emit_r == E_SEQ) ? (cfg_hit_r ? 5'd18 : 5'd16)
                                          : (fr_aac_r ? 5'd16 : 5'd15);
  assign tag_end      = (idx_r == tag_last_idx);

  // header byte at the current position
  always_comb begin
    case (idx_r)
      5'd1:    cur_byte = tag_prev[23:16];
      5'd2:    cur_byte = tag_prev[15:8];
      5'd3:    cur_byte = tag_prev[7:0];
      5'd4:    cur_byte = TAG_TYPE_AUDIO;
      5'd5:    cur_byte = tag_dsize[23:16];
      5'd6:    cur_byte = tag_dsize[15:8];
      5'd7:    cur_byte = tag_dsize[7:0];
      5'd8:    cur_byte = ts_snap_r[23:16];
      5'd9:    cur_byte = ts_snap_r[15:8];
      5'd10:   cur_byte = ts_snap_r[7:0];
      5'd11:   cur_byte = ts_snap_r[31:24];
      5'd15:   cur_byte = (emit_r == E_SEQ) ? FLAGS_AAC : fr_flag_r;
      5'd16:   cur_byte = (emit_r == E_SEQ) ? AAC_PKT_SEQ : AAC_PKT_RAW;
      5'd17:   cur_byte = cfg_b0_r;
      5'd18:   cur_byte = cfg_b1_r;
      default: cur_byte = 8'h00;
    endcase
  end

  // emitter and output register
  always_comb begin
    emit_nxt      = emit_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_r != E_IDLE && out_ready) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.tag_byte  = cur_byte;
      out_data_nxt.last_byte = tag_end && (emit_r == E_FRAME);
      if (tag_end) begin
        emit_nxt = (emit_r == E_SEQ) ? E_FRAME : E_IDLE;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 5'd1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      emit_nxt = seq_needed ? E_SEQ : E_FRAME;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= CODEC_MP3;
      first_done_r <= 1'b0;
      flags_r      <= FLAGS_MP3;
      prev_r       <= '0;
      ts_r         <= '0;
      total_r      <= '0;
      start_r      <= 1'b0;
      emit_r       <= E_IDLE;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      codec_mode_r <= codec_mode_nxt;
      first_done_r <= first_done_nxt;
      flags_r      <= flags_nxt;
      prev_r       <= prev_nxt;
      ts_r         <= ts_nxt;
      total_r      <= total_nxt;
      start_r      <= start_nxt;
      emit_r       <= emit_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // timestamp divider, started the cycle after the sample total moves
  flvahp_div #(
    .TOTAL_W (SAMPLE_TOTAL_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .total  (total_r),
    .rate   (rate_r),
    .status (div_stat),
    .quo    (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/flvahp_checker.sv
// Port-level checks of the FLV audio tag header packer, bound to the top level
`include "flv_audio_tag_header_packer_defines.svh"

module flvahp_checker
  import flvahp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  `FLVAHP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // an accepted item blocks the input on the next cycle
  `FLVAHP_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after transfer")

  // no new item while a frame's header is only partly out
  `FLVAHP_ASSERT_IMP(a_no_in_mid_frame, clk, rst_n, out_valid && !out_data.last_byte, in_stall, "input open mid frame")

  // a new tag always opens with the zero top byte of previous tag size
  `FLVAHP_ASSERT_NXT(a_tag_opens_zero, clk, rst_n, out_valid && !out_stall && out_data.last_byte, !out_valid || out_data.tag_byte == 8'h00, "tag does not open with zero")

endmodule

bind flv_audio_tag_header_packer flvahp_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/flv_audio_tag_header_packer_tb.sv
// Self-checking bench, FLV audio tag header packer: directed and random frames, byte checks
module flv_audio_tag_header_packer_tb import flvahp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_FRAMES  = 49;
  localparam int HOLD_AT_BYTES = 1500;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_PRINTED   = 50;

  // Predicts the header byte stream and checks each byte transfer against it
  class tag_header_scoreboard;
    bit         codec_aac;
    bit [47:0]  sample_total;
    bit [31:0]  timestamp_ms;
    bit [23:0]  prev_tag_size;
    bit [7:0]   audio_flags;
    bit         first_done;
    out_item_t  header_bytes_due[$];
    int         bytes_checked;
    int         errors;

    function new();
      codec_aac     = CODEC_MP3;
      sample_total  = '0;
      timestamp_ms  = '0;
      prev_tag_size = '0;
      audio_flags   = FLAGS_MP3;
      first_done    = 1'b0;
      bytes_checked = 0;
      errors        = 0;
    endfunction

    function void report(string msg);
      if (errors < MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
    endfunction

    function void push_byte(bit [7:0] b);
      out_item_t e;
      e.tag_byte  = b;
      e.last_byte = 1'b0;
      header_bytes_due.push_back(e);
    endfunction

    // previous tag size, type, data size, timestamp, stream id
    function void push_tag_header(bit [23:0] data_size);
      push_byte(8'h00);
      push_byte(prev_tag_size[23:16]);
      push_byte(prev_tag_size[15:8]);
      push_byte(prev_tag_size[7:0]);
      push_byte(TAG_TYPE_AUDIO);
      push_byte(data_size[23:16]);
      push_byte(data_size[15:8]);
      push_byte(data_size[7:0]);
      push_byte(timestamp_ms[23:16]);
      push_byte(timestamp_ms[15:8]);
      push_byte(timestamp_ms[7:0]);
      push_byte(timestamp_ms[31:24]);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h00);
    endfunction

    // running sample total; a zero rate leaves the timestamp alone
    function void advance_clock(bit [11:0] cnt, bit [RATE_W-1:0] rate);
      longint unsigned scaled;
      sample_total = sample_total + 48'(cnt);
      if (rate != '0) begin
        scaled       = 64'(sample_total) * 64'd1000;
        timestamp_ms = 32'(scaled / 64'(rate));
      end
    endfunction

    function void note_frame(in_item_t f);
      bit [FRAME_LEN_W-1:0] hdr;
      bit [FRAME_LEN_W-1:0] pay_len;
      bit [1:0]             rate_code;
      bit                   hit;
      int                   idx;
      if (codec_aac == CODEC_MP3) begin
        // flag byte latched from the first MP3 frame only
        if (audio_flags == FLAGS_MP3) begin
          rate_code = (f.sample_rate == RATE_11K) ? MP3_RATE_11K :
                      (f.sample_rate == RATE_22K) ? MP3_RATE_22K : MP3_RATE_OTHER;
          audio_flags = FLAGS_MP3 | {4'b0, rate_code, 1'b0, f.channel_count == 3'd2};
        end
        first_done = 1'b1;
        push_tag_header(24'(f.frame_len) + 24'd1);
        push_byte(audio_flags);
        advance_clock(f.frame_samples, f.sample_rate);
        prev_tag_size = 24'(f.frame_len) + 24'd12;
      end else begin
        hdr     = (f.sync_len > f.frame_len) ? f.frame_len : FRAME_LEN_W'(f.sync_len);
        pay_len = f.frame_len - hdr;
        // sequence header tag in front of the first AAC frame
        if (!first_done) begin
          idx = 0;
          while (idx < 13 && AAC_RATES[idx] != f.sample_rate) idx++;
          hit = (idx < 13);
          push_tag_header(hit ? 24'd4 : 24'd2);
          push_byte(FLAGS_AAC);
          push_byte(AAC_PKT_SEQ);
          if (hit) begin
            push_byte(AAC_OBJ_LC | 8'(idx >> 1));
            push_byte(8'((idx << 7) & 255) | {2'b0, f.channel_count, 3'b0});
          end
          prev_tag_size = hit ? 24'd15 : 24'd13;
          audio_flags   = FLAGS_AAC;
          first_done    = 1'b1;
        end
        push_tag_header(24'(pay_len) + 24'd2);
        push_byte(FLAGS_AAC);
        push_byte(AAC_PKT_RAW);
        advance_clock(f.frame_samples, f.sample_rate);
        prev_tag_size = 24'(pay_len) + 24'd13;
      end
      header_bytes_due[header_bytes_due.size() - 1].last_byte = 1'b1;
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (header_bytes_due.size() == 0) begin
        report($sformatf("byte %0d: %02h with nothing expected", bytes_checked, got.tag_byte));
      end else begin
        want = header_bytes_due.pop_front();
        if (got.tag_byte !== want.tag_byte) begin
          report($sformatf("byte %0d: tag_byte %02h, want %02h",
                           bytes_checked, got.tag_byte, want.tag_byte));
        end
        if (got.last_byte !== want.last_byte) begin
          report($sformatf("byte %0d: last_byte %0b, want %0b",
                           bytes_checked, got.last_byte, want.last_byte));
        end
      end
      bytes_checked++;
    endfunction
  endclass

  logic              clk;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  tag_header_scoreboard sb = new();

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   bytes_seen    = 0;
  logic hold_on       = 1'b0;
  int   cycles        = 0;

  flv_audio_tag_header_packer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("flv_audio_tag_header_packer_tb: FAIL");
      $finish;
    end
  end

  // one long hold-off of the result side once traffic is well under way
  initial begin
    wait (bytes_seen >= HOLD_AT_BYTES);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // result side: check each transfer, random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_byte(out_data);
        bytes_seen++;
      end
      out_stall <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic in_item_t frame_of(int fl, int hl, int cnt, int rate, int ch);
    in_item_t f;
    f.frame_len     = FRAME_LEN_W'(fl);
    f.sync_len      = 4'(hl);
    f.frame_samples = 12'(cnt);
    f.sample_rate   = RATE_W'(rate);
    f.channel_count = 3'(ch);
    return f;
  endfunction

  function automatic in_item_t random_frame();
    in_item_t f;
    int       pick;
    // short frames now and then so the header clamp is hit
    f.frame_len     = ($urandom_range(0, 7) == 0) ? FRAME_LEN_W'($urandom_range(0, 15))
                                                  : FRAME_LEN_W'($urandom_range(0, 8191));
    f.sync_len      = 4'($urandom_range(0, 15));
    f.frame_samples = 12'($urandom_range(0, 4095));
    f.channel_count = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 19);
    case (pick)
      0:            f.sample_rate = '0;
      1:            f.sample_rate = RATE_11K;
      2:            f.sample_rate = RATE_22K;
      3, 4, 5, 6:   f.sample_rate = AAC_RATES[$urandom_range(0, 12)];
      7, 8:         f.sample_rate = RATE_W'($urandom_range(1, 50));
      default:      f.sample_rate = RATE_W'($urandom_range(0, 96000));
    endcase
    return f;
  endfunction

  // 0: sender idles 30%, receiver 83%; 1: the other way round; 2: no idling
  task automatic set_idling(int profile);
    case (profile)
      0:       begin send_idle_pct = 30; recv_idle_pct = 83; end
      1:       begin send_idle_pct = 83; recv_idle_pct = 30; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  task automatic send_frame(in_item_t f);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
    sb.note_frame(f);
  endtask

  // let all expected bytes arrive, then give the divider time to finish
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.header_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write then read back codec_mode
  task automatic write_codec_mode(logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({REG_CODEC_MODE, 2'b00});
    pwdata  <= {31'b0, mode};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, mode}) begin
      sb.report($sformatf("codec_mode read %08h, want %0b", prdata, mode));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.codec_aac = mode;
  endtask

  // field extremes, header clamp, zero and tiny rates, odd channel counts
  task automatic directed_frames();
    send_frame(frame_of(0, 0, 0, 0, 0));
    send_frame(frame_of(8191, 15, 4095, 96000, 7));
    send_frame(frame_of(5, 15, 4095, 1, 2));
    send_frame(frame_of(8191, 0, 4095, 1, 0));
    send_frame(frame_of(100, 7, 1152, 48000, 2));
    send_frame(frame_of(0, 15, 0, 7350, 3));
    send_frame(frame_of(4095, 8, 2048, 96000, 5));
  endtask

  initial begin
    int   start_kind;
    int   first_rate;
    logic mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the first frame decides latch or sequence header, so pick it per seed
    start_kind = $urandom_range(0, 2);
    mode       = (start_kind == 0) ? CODEC_MP3 : CODEC_AAC;
    case (start_kind)
      0: begin
        case ($urandom_range(0, 2))
          0:       first_rate = RATE_11K;
          1:       first_rate = RATE_22K;
          default: first_rate = 44100;
        endcase
      end
      1:       first_rate = AAC_RATES[$urandom_range(0, 12)];
      default: first_rate = 44000;
    endcase
    set_idling(0);
    write_codec_mode(mode);
    send_frame(frame_of($urandom_range(0, 8191), $urandom_range(0, 15),
                        $urandom_range(0, 4095), first_rate,
                        $urandom_range(0, 1) ? 2 : $urandom_range(0, 7)));
    directed_frames();

    // mode change after the first frame
    drain();
    mode = ~mode;
    write_codec_mode(mode);
    directed_frames();

    // random phases, alternating codec, idling profile stepping through
    for (int p = 0; p < 6; p++) begin
      drain();
      mode = ~mode;
      write_codec_mode(mode);
      set_idling(p / 2);
      repeat (PHASE_FRAMES) send_frame(random_frame());
    end

    drain();
    if (sb.errors == 0) begin
      $display("flv_audio_tag_header_packer_tb: PASS");
    end else begin
      $display("flv_audio_tag_header_packer_tb: FAIL");
    end
    $finish;
  end

endmodule
